### rtl/syscall_filter_rule_engine_top_assert.svh
// assertion macros shared by the checker
`ifndef SYSCALL_FILTER_RULE_ENGINE_TOP_ASSERT_SVH
`define SYSCALL_FILTER_RULE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define SFRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define SFRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define SFRE_ASSERT_ALW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sfre_pkg.sv
package sfre_pkg;

  localparam int CALL_ARGS = 6;

  localparam logic [2:0] FN_SET_MODE = 3'd0;
  localparam logic [2:0] FN_ADD_RULE = 3'd1;
  localparam logic [2:0] FN_CHECK    = 3'd2;
  localparam logic [2:0] FN_GET_MODE = 3'd3;
  localparam logic [2:0] FN_RELEASE  = 3'd4;

  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_STRICT   = 2'd1;
  localparam logic [1:0] MODE_FILTER   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_PERM    = 2'd3;

  localparam logic [7:0] OP_EQ  = 8'h10;
  localparam logic [7:0] OP_GT  = 8'h20;
  localparam logic [7:0] OP_GE  = 8'h30;
  localparam logic [7:0] OP_LT  = 8'h40;
  localparam logic [7:0] OP_LE  = 8'h50;
  localparam logic [7:0] OP_AND = 8'h60;

  localparam logic [2:0] ARG_NONE_MIN = 3'd6;

  localparam logic [0:0] REG_KILL = 1'b0;
  localparam logic [0:0] REG_DENY = 1'b1;

  localparam logic [31:0] KILL_RESET = 32'h8000_0000;
  localparam logic [31:0] DENY_RESET = 32'h0005_000D;

  localparam logic [9:0] SAFE_CALLS [8] = '{10'd0, 10'd1, 10'd9, 10'd11,
                                            10'd12, 10'd15, 10'd60, 10'd231};

  typedef struct packed {
    logic [2:0]                 func;
    logic [31:0]                pid;
    logic [9:0]                 call_number;
    logic [CALL_ARGS-1:0][63:0] args;
    logic [31:0]                action_or_mode;
    logic [2:0]                 cond_arg_index;
    logic [7:0]                 cond_op;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] verdict;
    logic [1:0]  mode_out;
  } result_t;

  typedef struct packed {
    logic [7:0]  cond_op;
    logic [2:0]  arg_index;
    logic [31:0] action;
    logic [9:0]  call_number;
    logic [63:0] compare_value;
  } rule_t;

  typedef struct packed {
    logic latch;
    logic scan;
    logic exec;
    logic rule;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rule_done;
    logic out_free;
  } sts_t;

  function automatic logic is_safe(input logic [9:0] nr);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (SAFE_CALLS[i] == nr) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

### rtl/sfre_ifs.sv
interface sfre_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] pid;
  logic [9:0]  call_number;
  logic [63:0] arg0;
  logic [63:0] arg1;
  logic [63:0] arg2;
  logic [63:0] arg3;
  logic [63:0] arg4;
  logic [63:0] arg5;
  logic [31:0] action_or_mode;
  logic [2:0]  cond_arg_index;
  logic [7:0]  cond_op;
  modport source (output valid, func, pid, call_number, arg0, arg1, arg2, arg3, arg4,
                  arg5, action_or_mode, cond_arg_index, cond_op, input ready);
  modport sink (input valid, func, pid, call_number, arg0, arg1, arg2, arg3, arg4,
                arg5, action_or_mode, cond_arg_index, cond_op, output ready);
endinterface

interface sfre_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] verdict;
  logic [1:0]  mode_out;
  modport source (output valid, status, verdict, mode_out, input ready);
  modport sink (input valid, status, verdict, mode_out, output ready);
endinterface

### rtl/sfre_ctrl.sv
module sfre_ctrl
  import sfre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_RULE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RULE;
      end
      S_RULE: begin
        cmd.rule = 1'b1;
        if (sts.rule_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/sfre_dp.sv
module sfre_dp
  import sfre_pkg::*;
#(
  parameter int PROCESS_SLOTS     = 16,
  parameter int RULES_PER_PROCESS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  item_t       item,
  input  logic [31:0] kill_code,
  input  logic [31:0] deny_code,
  input  logic        out_ready,
  output logic        out_valid,
  output result_t     out_res
);

  localparam int SW   = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int SCW  = $clog2(PROCESS_SLOTS + 1);
  localparam int RCW  = $clog2(RULES_PER_PROCESS + 1);
  localparam int NR   = PROCESS_SLOTS * RULES_PER_PROCESS;
  localparam int AW   = (NR > 1) ? $clog2(NR) : 1;
  localparam int SLW  = 32 + 2 + RCW;
  localparam logic [SCW-1:0] SLOTS_C = SCW'(PROCESS_SLOTS);
  localparam logic [RCW-1:0] RULES_C = RCW'(RULES_PER_PROCESS);
  localparam logic [AW-1:0]  RULES_A = AW'(RULES_PER_PROCESS);

  // slot word: pid, mode, rule count
  logic [SLW-1:0] slot_mem [PROCESS_SLOTS];
  rule_t          rule_mem [NR];
  logic [PROCESS_SLOTS-1:0] used_r;

  item_t          item_r;
  logic [SLW-1:0] slot_rd_r;
  rule_t          rule_rd_r;

  logic [SCW-1:0] scan_i_r;
  logic           rd_pend_r;
  logic [SW-1:0]  rd_idx_r;
  logic           found_r, free_found_r;
  logic [SW-1:0]  found_idx_r, free_idx_r;
  logic [1:0]     found_mode_r;
  logic [RCW-1:0] found_cnt_r;

  logic           need_rules_r, rmatch_r, rpend_r;
  logic [RCW-1:0] rk_i_r;
  logic [AW-1:0]  rule_base_r;

  result_t        res_r;
  result_t        out_res_r;
  logic           out_valid_r;

  // scan issue and address
  logic           scan_issue;
  logic [SW-1:0]  scan_addr;
  logic           rd_used, rd_hit;
  assign scan_issue = cmd.scan && (scan_i_r < SLOTS_C) && !found_r;
  assign scan_addr  = scan_i_r[SW-1:0];
  assign rd_used    = used_r[rd_idx_r];
  assign rd_hit     = rd_pend_r && rd_used && (slot_rd_r[SLW-1 -: 32] == item_r.pid);

  // rule walk issue
  logic           rule_issue;
  logic [AW-1:0]  rule_addr;
  assign rule_issue = cmd.rule && need_rules_r && !rmatch_r && (rk_i_r < found_cnt_r);
  assign rule_addr  = rule_base_r + AW'(rk_i_r);

  // condition test on the rule read back
  logic [63:0] sel_arg;
  logic        cond_ok, rule_hit;
  always_comb begin
    sel_arg = item_r.args[0];
    for (int i = 0; i < CALL_ARGS; i++) begin
      if (rule_rd_r.arg_index == 3'(i)) sel_arg = item_r.args[i];
    end
    if (rule_rd_r.arg_index >= ARG_NONE_MIN) begin
      cond_ok = 1'b1;
    end else begin
      case (rule_rd_r.cond_op)
        OP_EQ:   cond_ok = (sel_arg == rule_rd_r.compare_value);
        OP_GT:   cond_ok = (sel_arg >  rule_rd_r.compare_value);
        OP_GE:   cond_ok = (sel_arg >= rule_rd_r.compare_value);
        OP_LT:   cond_ok = (sel_arg <  rule_rd_r.compare_value);
        OP_LE:   cond_ok = (sel_arg <= rule_rd_r.compare_value);
        OP_AND:  cond_ok = ((sel_arg & rule_rd_r.compare_value) != 64'd0);
        default: cond_ok = 1'b0;
      endcase
    end
  end
  assign rule_hit = rpend_r && !rmatch_r && (rule_rd_r.call_number == item_r.call_number)
                    && cond_ok;

  // operation decision
  logic           have_slot;
  logic [SW-1:0]  slot_sel;
  logic [1:0]     cur_mode;
  logic [RCW-1:0] cur_cnt;
  logic           slot_we, rule_we, used_set, used_clr, need_rules_nxt;
  logic [SLW-1:0] slot_wdata;
  logic [AW-1:0]  rule_waddr;
  result_t        res_nxt;
  always_comb begin
    have_slot      = found_r || free_found_r;
    slot_sel       = found_r ? found_idx_r : free_idx_r;
    cur_mode       = found_r ? found_mode_r : MODE_DISABLED;
    cur_cnt        = found_r ? found_cnt_r : '0;
    slot_we        = 1'b0;
    rule_we        = 1'b0;
    used_set       = 1'b0;
    used_clr       = 1'b0;
    need_rules_nxt = 1'b0;
    slot_wdata     = {item_r.pid, cur_mode, cur_cnt};
    rule_waddr     = AW'(AW'(slot_sel) * RULES_A) + AW'(cur_cnt);
    res_nxt        = '0;
    case (item_r.func)
      FN_SET_MODE: begin
        if (item_r.action_or_mode > 32'(MODE_FILTER)) begin
          res_nxt.status = ST_INVALID;
        end else if (!have_slot) begin
          res_nxt.status = ST_FULL;
        end else if (item_r.action_or_mode[1:0] < cur_mode) begin
          res_nxt.status = ST_PERM;
        end else begin
          slot_we    = 1'b1;
          used_set   = 1'b1;
          slot_wdata = {item_r.pid, item_r.action_or_mode[1:0], cur_cnt};
        end
      end
      FN_ADD_RULE: begin
        if (!have_slot || cur_cnt >= RULES_C) begin
          res_nxt.status = ST_FULL;
        end else begin
          slot_we    = 1'b1;
          rule_we    = 1'b1;
          used_set   = 1'b1;
          slot_wdata = {item_r.pid, cur_mode, RCW'(cur_cnt + 1'b1)};
        end
      end
      FN_CHECK: begin
        if (found_r && found_mode_r == MODE_STRICT) begin
          res_nxt.verdict = is_safe(item_r.call_number) ? 32'd0 : kill_code;
        end else if (found_r && found_mode_r[1]) begin
          res_nxt.verdict = deny_code;
          need_rules_nxt  = 1'b1;
        end
      end
      FN_GET_MODE: begin
        res_nxt.mode_out = cur_mode;
      end
      FN_RELEASE: begin
        used_clr = found_r;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_rd_r <= slot_mem[scan_addr];
    rule_rd_r <= rule_mem[rule_addr];
    if (cmd.exec && slot_we) slot_mem[slot_sel] <= slot_wdata;
    if (cmd.exec && rule_we) begin
      rule_mem[rule_waddr] <= '{cond_op:       item_r.cond_op,
                                arg_index:     item_r.cond_arg_index,
                                action:        item_r.action_or_mode,
                                call_number:   item_r.call_number,
                                compare_value: item_r.args[0]};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= item;
    if (rd_hit && !found_r) begin
      found_idx_r  <= rd_idx_r;
      found_mode_r <= slot_rd_r[RCW +: 2];
      found_cnt_r  <= slot_rd_r[RCW-1:0];
    end
    if (rd_pend_r && !rd_used && !free_found_r) free_idx_r <= rd_idx_r;
    if (scan_issue) rd_idx_r <= scan_addr;
    if (cmd.exec) begin
      res_r       <= res_nxt;
      rule_base_r <= AW'(AW'(found_idx_r) * RULES_A);
    end else if (rule_hit) begin
      res_r.verdict <= rule_rd_r.action;
    end
    if (cmd.exec) rk_i_r <= '0;
    else if (rule_issue) rk_i_r <= RCW'(rk_i_r + 1'b1);
    // result beat held here while the next operation works in res_r
    if (cmd.load) out_res_r <= res_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      scan_i_r     <= '0;
      rd_pend_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      need_rules_r <= 1'b0;
      rmatch_r     <= 1'b0;
      rpend_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.latch) begin
        scan_i_r     <= '0;
        rd_pend_r    <= 1'b0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (scan_issue) scan_i_r <= SCW'(scan_i_r + 1'b1);
        rd_pend_r <= scan_issue;
        if (rd_hit) found_r <= 1'b1;
        if (rd_pend_r && !rd_used) free_found_r <= 1'b1;
      end
      if (cmd.exec) begin
        need_rules_r <= need_rules_nxt;
        rmatch_r     <= 1'b0;
        rpend_r      <= 1'b0;
        if (used_set) used_r[slot_sel] <= 1'b1;
        if (used_clr) used_r[found_idx_r] <= 1'b0;
      end else begin
        rpend_r <= rule_issue;
        if (rule_hit) rmatch_r <= 1'b1;
      end
      if (cmd.load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.scan_done = found_r || (scan_i_r == SLOTS_C && !rd_pend_r);
  assign sts.rule_done = !need_rules_r || rmatch_r || rule_hit
                         || (rk_i_r == found_cnt_r && !rpend_r);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_res       = out_res_r;

endmodule

### rtl/syscall_filter_rule_engine_top.sv
// result: the beat is loaded after the slot scan, the execute step and the rule walk
// handshake: a new beat is taken the cycle after the result is loaded;
//   slot scan and rule walk read one memory word per cycle each
// reset: synchronous active-low rst_n clears slot valid bits, the controller and
//   the output valid; codes return to kill 0x80000000 and deny 0x0005000D
module syscall_filter_rule_engine_top
  import sfre_pkg::*;
#(
  parameter int PROCESS_SLOTS     = 16,
  parameter int RULES_PER_PROCESS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sfre_in_if.sink     in_ch,
  sfre_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers, kill code at 0x0 and deny code at 0x4
  logic [31:0] kill_code_r, deny_code_r;
  logic        cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kill_code_r <= KILL_RESET;
      deny_code_r <= DENY_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_KILL) kill_code_r <= cfg_pwdata;
      else                          deny_code_r <= cfg_pwdata;
    end
  end

  // read mux, only bit 2 of the address picks the register
  assign cfg_prdata = (cfg_paddr[2] == REG_DENY) ? deny_code_r : kill_code_r;

  // pack the input beat for the datapath
  item_t   item;
  assign item.func           = in_ch.func;
  assign item.pid            = in_ch.pid;
  assign item.call_number    = in_ch.call_number;
  assign item.args[0]        = in_ch.arg0;
  assign item.args[1]        = in_ch.arg1;
  assign item.args[2]        = in_ch.arg2;
  assign item.args[3]        = in_ch.arg3;
  assign item.args[4]        = in_ch.arg4;
  assign item.args[5]        = in_ch.arg5;
  assign item.action_or_mode = in_ch.action_or_mode;
  assign item.cond_arg_index = in_ch.cond_arg_index;
  assign item.cond_op        = in_ch.cond_op;

  cmd_t    cmd;
  sts_t    sts;
  result_t res;

  // controller: idle, slot scan, execute, rule walk, hand off result
  sfre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: slot table, rule store, compare logic, output register
  sfre_dp #(
    .PROCESS_SLOTS     (PROCESS_SLOTS),
    .RULES_PER_PROCESS (RULES_PER_PROCESS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .kill_code (kill_code_r),
    .deny_code (deny_code_r),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (res)
  );

  // the output register holds a beat while the next one is being worked on
  assign out_ch.status   = res.status;
  assign out_ch.verdict  = res.verdict;
  assign out_ch.mode_out = res.mode_out;

endmodule

### rtl/sfre_checker.sv
`include "syscall_filter_rule_engine_top_assert.svh"

module sfre_checker
  import sfre_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_verdict,
  input logic [1:0]  out_mode_out
);

  `SFRE_ASSERT_ALW(a_reset_no_out, clk, !rst_n, !out_valid, "result beat right after reset")
  `SFRE_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "took a beat while busy")
  `SFRE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_verdict), "stalled result changed")
  `SFRE_ASSERT_NOW(a_fail_no_verdict, clk, rst_n, out_valid && out_status != ST_OK, out_verdict == 32'd0 && out_mode_out == MODE_DISABLED, "failed op carries data")

endmodule

bind syscall_filter_rule_engine_top sfre_checker u_sfre_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_verdict  (out_ch.verdict),
  .out_mode_out (out_ch.mode_out)
);
